// ----- sv/slot_allocator_lazy_reclaim_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Concurrent assertion helpers that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_LAZY_RECLAIM_CORE_MACROS_SVH
`define SLOT_ALLOCATOR_LAZY_RECLAIM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define SA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SA_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/sala_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot allocator package
// Pool size, derived widths and action codes.
// ----------------------------------------------------------------------------
`default_nettype none
package sala_pkg;
	localparam int SLOTS  = 256;
	localparam int SLOT_W = 8;
	localparam int CNT_W  = 9;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int TOP_W  = $clog2(SLOTS + 1);

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_REBUILD = 2'd2;
endpackage
`default_nettype wire

// ----- sv/slot_allocator_lazy_reclaim_core.sv -----
// Release, undefined codes and allocate on an empty free list go from idle straight to
// ST_DONE; allocate passes ST_ALLOC and rebuild passes ST_SCAN first. ST_DONE loads the
// result register once the output is free. A new beat is accepted only back in idle,
// after the previous result is registered; rebuild streams the in-use memory once.
// Reset is asynchronous and takes effect at once: no clearing pass, the free list reads
// as the identity until the first rebuild and the in-use bits carry per-entry valid flags.
`default_nettype none
// ----------------------------------------------------------------------------
// Slot allocator with lazy reclaim
// Free-list stack and in-use bits kept in synchronous memories; rebuild scans
// the in-use memory and rewrites the free list in ascending order.
// ----------------------------------------------------------------------------
`include "slot_allocator_lazy_reclaim_core_macros.svh"
module slot_allocator_lazy_reclaim_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   action,
	input  wire logic [sala_pkg::SLOT_W-1:0]  slot,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              granted,
	output logic [sala_pkg::SLOT_W-1:0]       slot_out,
	output logic [sala_pkg::CNT_W-1:0]        free_count,
	output logic                              full_res,
	output logic                              empty_res
);
	typedef enum logic [1:0] {ST_IDLE, ST_ALLOC, ST_SCAN, ST_DONE} state_t;

	localparam int IW = sala_pkg::IDX_W;
	localparam int TW = sala_pkg::TOP_W;

	state_t            state_q;
	logic [TW-1:0]     free_top_q;
	logic              rebuilt_q;
	logic              res_granted_q;
	logic [IW-1:0]     res_slot_q;
	logic [TW-1:0]     scan_idx_q;
	logic [TW-1:0]     n_q;
	logic              rd_vld_s1;
	logic [IW-1:0]     scan_slot_s1;
	logic [IW-1:0]     alloc_addr_s1;
	logic              out_valid_q;
	logic              granted_q;
	logic [sala_pkg::SLOT_W-1:0] slot_out_q;
	logic [sala_pkg::CNT_W-1:0]  free_count_q;
	logic              full_q;
	logic              empty_q;

	logic [IW-1:0]     free_stack_mem [sala_pkg::SLOTS];
	logic              in_use_mem [sala_pkg::SLOTS];
	logic [sala_pkg::SLOTS-1:0] in_use_v_q;
	logic [IW-1:0]     fs_rd_s1;
	logic              iu_rd_s1;
	logic              iu_v_s1;

	logic              in_fire;
	logic [TW-1:0]     top_m1;
	logic [IW-1:0]     fs_raddr;
	logic              scan_issue;
	logic [IW-1:0]     scan_addr;
	logic              scan_free;
	logic              fs_we;
	logic [IW-1:0]     alloc_slot;
	logic              slot_ok;
	logic              iu_we;
	logic [IW-1:0]     iu_waddr;
	logic              iu_wdata;
	logic              out_free;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign top_m1     = free_top_q - TW'(1);
	assign fs_raddr   = top_m1[IW-1:0];
	assign scan_issue = (scan_idx_q < TW'(sala_pkg::SLOTS));
	assign scan_addr  = scan_idx_q[IW-1:0];
	assign scan_free  = rd_vld_s1 && !(iu_v_s1 && iu_rd_s1);
	assign fs_we      = (state_q == ST_SCAN) && scan_free;
	assign slot_ok    = (TW'(slot) < TW'(sala_pkg::SLOTS));
	assign out_free   = !out_valid_q || out_ready;

	// Until the first rebuild the free list still holds its reset image, so the
	// popped entry equals its own position.
	assign alloc_slot = rebuilt_q ? fs_rd_s1 : alloc_addr_s1;

	always_comb begin
		iu_we    = 1'b0;
		iu_waddr = alloc_slot;
		iu_wdata = 1'b1;
		if (state_q == ST_ALLOC) begin
			iu_we = 1'b1;
		end else if (in_fire && action == sala_pkg::ACT_RELEASE && slot_ok) begin
			iu_we    = 1'b1;
			iu_waddr = IW'(slot);
			iu_wdata = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		fs_rd_s1 <= free_stack_mem[fs_raddr];
		if (fs_we) begin
			free_stack_mem[n_q[IW-1:0]] <= scan_slot_s1;
		end
	end

	always_ff @(posedge clk) begin
		iu_rd_s1 <= in_use_mem[scan_addr];
		if (iu_we) begin
			in_use_mem[iu_waddr] <= iu_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_v_q <= '0;
			iu_v_s1    <= 1'b0;
		end else begin
			iu_v_s1 <= in_use_v_q[scan_addr];
			if (iu_we) begin
				in_use_v_q[iu_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			free_top_q    <= TW'(sala_pkg::SLOTS);
			rebuilt_q     <= 1'b0;
			res_granted_q <= 1'b0;
			res_slot_q    <= '0;
			scan_idx_q    <= '0;
			n_q           <= '0;
			rd_vld_s1     <= 1'b0;
			scan_slot_s1  <= '0;
			alloc_addr_s1 <= '0;
			out_valid_q   <= 1'b0;
			granted_q     <= 1'b0;
			slot_out_q    <= '0;
			free_count_q  <= '0;
			full_q        <= 1'b0;
			empty_q       <= 1'b0;
		end else begin
			// In the result state a taken beat is replaced by the next one below.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_slot_q <= '0;
						case (action)
							sala_pkg::ACT_ALLOC: begin
								res_granted_q <= 1'b0;
								if (free_top_q != '0) begin
									free_top_q    <= top_m1;
									alloc_addr_s1 <= fs_raddr;
									state_q       <= ST_ALLOC;
								end else begin
									state_q <= ST_DONE;
								end
							end
							sala_pkg::ACT_RELEASE: begin
								res_granted_q <= slot_ok;
								state_q       <= ST_DONE;
							end
							sala_pkg::ACT_REBUILD: begin
								res_granted_q <= 1'b0;
								scan_idx_q    <= '0;
								n_q           <= '0;
								rd_vld_s1     <= 1'b0;
								state_q       <= ST_SCAN;
							end
							default: begin
								res_granted_q <= 1'b0;
								state_q       <= ST_DONE;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					res_granted_q <= 1'b1;
					res_slot_q    <= alloc_slot;
					state_q       <= ST_DONE;
				end
				ST_SCAN: begin
					// Reads are issued one slot a cycle; the free test and the
					// free-list write happen in the cycle after each read is issued.
					if (scan_issue) begin
						scan_idx_q   <= scan_idx_q + TW'(1);
						scan_slot_s1 <= scan_addr;
						rd_vld_s1    <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (scan_free) begin
						n_q <= n_q + TW'(1);
					end
					if (!scan_issue && !rd_vld_s1) begin
						free_top_q    <= n_q;
						rebuilt_q     <= 1'b1;
						res_granted_q <= 1'b1;
						res_slot_q    <= '0;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						granted_q    <= res_granted_q;
						slot_out_q   <= sala_pkg::SLOT_W'(res_slot_q);
						free_count_q <= sala_pkg::CNT_W'(free_top_q);
						full_q       <= (free_top_q == '0);
						empty_q      <= (free_top_q == TW'(sala_pkg::SLOTS));
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign granted    = granted_q;
	assign slot_out   = slot_out_q;
	assign free_count = free_count_q;
	assign full_res   = full_q;
	assign empty_res  = empty_q;

	`SA_ASSERT_ALWAYS(a_top_range, clk, arst_n, free_top_q <= TW'(sala_pkg::SLOTS))
	`SA_ASSERT_IMPLIES(a_scan_count, clk, arst_n, state_q == ST_SCAN, n_q <= scan_idx_q)
	`SA_ASSERT_NEXT(a_alloc_pop, clk, arst_n,
		in_fire && action == sala_pkg::ACT_ALLOC && free_top_q != '0,
		free_top_q == $past(free_top_q) - TW'(1))
	`SA_ASSERT_IMPLIES(a_flags_excl, clk, arst_n, out_valid_q, !(full_q && empty_q))
endmodule
`default_nettype wire
